// File: hw/rtl/prc_pkg.sv
// Shared constants for the particle contact resolver.
// Fixed field widths and restitution format; no dependencies.
package prc_pkg;

  localparam int IM_BITS   = 20;     // inverse mass, unsigned Q8.12
  localparam int RST_BITS  = 16;     // restitution, unsigned Q1.15
  localparam int RST_ONE   = 32768;  // 1.0 in Q1.15
  localparam int RST_SHIFT = 15;
  localparam int FAC_BITS  = RST_BITS + 1;

endpackage

// File: hw/rtl/particle_contact_resolver.sv
// Particle contact resolver: impulse and penetration correction per contact.
// Depends on prc_pkg.
// The pipeline runs from the input registers to the output register through
// 57 restoring divider stages, one quotient bit each, at the default widths.
// Throughput: one item per cycle; the whole pipeline holds while an output item waits.
// Reset clears valid bits and restitution; payload registers are not reset.
module particle_contact_resolver #(
  parameter int COMPONENT_BITS = 21,
  parameter int FRACTION_BITS  = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [prc_pkg::RST_BITS-1:0] cfg_data,  // restitution
  input  logic s_tvalid,
  output logic s_tready,
  // vel_a, vel_b, pos_a, pos_b, contact_normal, pen_depth, inv_mass_a, inv_mass_b
  input  logic [((16*COMPONENT_BITS+2*prc_pkg::IM_BITS+7)/8)*8-1:0] s_tdata,
  input  logic [0:0] s_tuser,                      // has_second
  output logic m_tvalid,
  input  logic m_tready,
  // new_vel_a, new_vel_b, new_pos_a, new_pos_b, sep_speed
  output logic [((13*COMPONENT_BITS+7)/8)*8-1:0] m_tdata,
  output logic [1:0] m_tuser                       // velocity_changed, position_changed
);
  import prc_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int VW   = 3 * CB;
  localparam int DFW  = CB + 1;
  localparam int PRW  = DFW + CB;
  localparam int SMW  = PRW + 2;
  localparam int SPW  = SMW - FB;
  localparam int MW   = SPW + FAC_BITS;
  localparam int DW   = MW - RST_SHIFT;
  localparam int WB   = IM_BITS + 1;
  localparam int NB   = DW + IM_BITS;
  localparam int NQW  = CB + DW + 1;
  localparam int AW   = NQW - FB + 1;
  localparam int SATW = (AW > SPW) ? AW : SPW;
  localparam int OW   = ((13 * CB + 7) / 8) * 8;
  localparam int NV   = NB + 8;
  localparam int CHI  = (1 << (CB - 1)) - 1;
  localparam logic signed [SATW-1:0] SAT_HI = SATW'(CHI);
  localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

  typedef struct packed {
    logic [VW-1:0]              va;
    logic [VW-1:0]              vb;
    logic [VW-1:0]              pa;
    logic [VW-1:0]              pb;
    logic [VW-1:0]              nrm;
    logic [CB-1:0]              depth;
    logic [IM_BITS-1:0]         ima;
    logic                       two;
    logic [WB-1:0]              w;
    logic [2:0][DFW-1:0]        d;
    logic [2:0][PRW-1:0]        p;
    logic [SPW-1:0]             sep;
    logic                       vstep;
    logic                       pstep;
    logic [SPW-1:0]             nsep;
    logic [MW-1:0]              m;
    logic [DW-1:0]              dsp;
    logic [DW-1:0]              dep;
  } ctx_t;

  typedef struct packed {
    logic [NB-1:0] dvd;
    logic [NB-1:0] quo;
    logic [WB-1:0] rem;
  } div_t;

  function automatic logic [CB-1:0] sat_c(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[CB-1:0];
  endfunction

  logic [RST_BITS-1:0] restitution;
  logic                en;
  logic [NV-1:0]       vld;

  ctx_t c1, c2, c3, c4, c5, cq, cp;
  ctx_t c1_next, c2_next, c3_next, c4_next, c5_next;
  ctx_t cd [0:NB];
  div_t dv [0:NB];
  div_t pv [0:NB];
  logic [3:0][DW-1:0]          q, q_next;
  logic [3:0][2:0][NQW-1:0]    prod, prod_next;
  logic [OW-1:0]               m_tdata_next;

  assign cfg_ready = 1'b1;
  assign en        = ~m_tvalid | m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= '0;
    end else if (cfg_valid) begin
      restitution <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NV-2:0], s_tvalid};
      m_tvalid <= vld[NV-1];
    end
  end

  // unpack and form relative velocity
  always_comb begin
    logic signed [CB-1:0] av, bv;
    logic                 two;
    c1_next       = 'x;
    two           = s_tuser[0];
    c1_next.va    = s_tdata[VW-1:0];
    c1_next.vb    = s_tdata[2*VW-1:VW];
    c1_next.pa    = s_tdata[3*VW-1:2*VW];
    c1_next.pb    = s_tdata[4*VW-1:3*VW];
    c1_next.nrm   = s_tdata[5*VW-1:4*VW];
    c1_next.depth = s_tdata[5*VW+CB-1:5*VW];
    c1_next.ima   = s_tdata[5*VW+CB+IM_BITS-1:5*VW+CB];
    c1_next.two   = two;
    c1_next.w     = WB'(s_tdata[5*VW+CB+IM_BITS-1:5*VW+CB]) +
                    (two ? WB'(s_tdata[5*VW+CB+2*IM_BITS-1:5*VW+CB+IM_BITS]) : WB'(0));
    for (int j = 0; j < 3; j++) begin
      av = $signed(s_tdata[(2-j)*CB +: CB]);
      bv = $signed(s_tdata[VW+(2-j)*CB +: CB]);
      c1_next.d[j] = DFW'(av) - (two ? DFW'(bv) : DFW'(0));
    end
  end

  always_comb begin
    c2_next = c1;
    for (int j = 0; j < 3; j++) begin
      c2_next.p[j] = PRW'($signed(c1.d[j]) * $signed(c1.nrm[(2-j)*CB +: CB]));
    end
  end

  always_comb begin
    logic signed [SMW-1:0] sum;
    logic signed [SPW-1:0] sep;
    c3_next = c2;
    sum = SMW'($signed(c2.p[0])) + SMW'($signed(c2.p[1])) + SMW'($signed(c2.p[2]));
    sep = sum[SMW-1:FB];
    c3_next.sep   = sep;
    c3_next.vstep = (sep <= 0) && (c2.w != '0);
    c3_next.pstep = ($signed(c2.depth) > 0) && (c2.w != '0);
    c3_next.nsep  = (sep <= 0) ? SPW'(-sep) : '0;
  end

  always_comb begin
    logic [FAC_BITS-1:0] fac;
    c4_next = c3;
    fac = FAC_BITS'(RST_ONE) + FAC_BITS'(restitution);
    c4_next.m = MW'(fac) * MW'(c3.nsep);
  end

  always_comb begin
    c5_next = c4;
    c5_next.dsp = c4.m[MW-1:RST_SHIFT];
    c5_next.dep = DW'(c4.depth[CB-2:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c1_next;
      c2 <= c2_next;
      c3 <= c3_next;
      c4 <= c4_next;
      c5 <= c5_next;
      cd[0] <= c5;
      dv[0].dvd <= NB'(c5.dsp * c5.ima);
      dv[0].quo <= '0;
      dv[0].rem <= '0;
      pv[0].dvd <= NB'(c5.dep[CB-2:0] * c5.ima);
      pv[0].quo <= '0;
      pv[0].rem <= '0;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [WB:0] tv, tp;
    logic        bv, bp;
    div_t        dv_next, pv_next;
    always_comb begin
      tv = {dv[k].rem, dv[k].dvd[NB-1]};
      tp = {pv[k].rem, pv[k].dvd[NB-1]};
      bv = (tv >= {1'b0, cd[k].w});
      bp = (tp >= {1'b0, cd[k].w});
      dv_next.dvd = dv[k].dvd << 1;
      dv_next.quo = {dv[k].quo[NB-2:0], bv};
      dv_next.rem = bv ? WB'(tv - {1'b0, cd[k].w}) : tv[WB-1:0];
      pv_next.dvd = pv[k].dvd << 1;
      pv_next.quo = {pv[k].quo[NB-2:0], bp};
      pv_next.rem = bp ? WB'(tp - {1'b0, cd[k].w}) : tp[WB-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cd[k+1] <= cd[k];
        dv[k+1] <= dv_next;
        pv[k+1] <= pv_next;
      end
    end
  end

  // share of B from the remainder of A: floor(x*imb/w) = x - ceil(x*ima/w)
  always_comb begin
    q_next[0] = dv[NB].quo[DW-1:0];
    q_next[1] = cd[NB].dsp - dv[NB].quo[DW-1:0] - DW'(dv[NB].rem != '0);
    q_next[2] = pv[NB].quo[DW-1:0];
    q_next[3] = cd[NB].dep - pv[NB].quo[DW-1:0] - DW'(pv[NB].rem != '0);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[k][j] = NQW'($signed(cq.nrm[(2-j)*CB +: CB]) * $signed({1'b0, q[k]}));
      end
    end
  end

  always_comb begin
    logic [3:0][VW-1:0]    base;
    logic [3:0][VW-1:0]    res;
    logic [3:0]            act;
    logic signed [CB-1:0]  comp;
    logic signed [AW-2:0]  dl;
    logic signed [AW-1:0]  sum;
    base = {cp.pb, cp.pa, cp.vb, cp.va};
    act  = {cp.pstep & cp.two, cp.pstep, cp.vstep & cp.two, cp.vstep};
    res  = base;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        comp = $signed(base[k][(2-j)*CB +: CB]);
        dl   = $signed(prod[k][j][NQW-1:FB]);
        sum  = k[0] ? (AW'(comp) - AW'(dl)) : (AW'(comp) + AW'(dl));
        if (act[k]) res[k][(2-j)*CB +: CB] = sat_c(SATW'(sum));
      end
    end
    m_tdata_next = OW'({sat_c(SATW'($signed(cp.sep))), res[3], res[2], res[1], res[0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cq      <= cd[NB];
      q       <= q_next;
      cp      <= cq;
      prod    <= prod_next;
      m_tdata <= m_tdata_next;
      m_tuser <= {cp.pstep, cp.vstep};
    end
  end

endmodule

// File: tb/particle_contact_checker.sv
`timescale 1ns / 100ps
// Contact checker: watches the contact and result streams of the resolver,
// predicts each resolved contact and compares. Depends on prc_pkg.
module particle_contact_checker #(
  parameter int COMPONENT_BITS = 21,
  parameter int FRACTION_BITS  = 10,
  parameter int IN_W  = ((16*COMPONENT_BITS+2*prc_pkg::IM_BITS+7)/8)*8,
  parameter int OUT_W = ((13*COMPONENT_BITS+7)/8)*8
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [prc_pkg::RST_BITS-1:0] cfg_data,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [IN_W-1:0] s_tdata,
  input  logic [0:0] s_tuser,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic [1:0] m_tuser,
  output int errors,
  output int pending
);
  localparam int C = COMPONENT_BITS;
  localparam int V = 3*C;

  typedef struct packed {
    logic [1:0] flags;
    logic [OUT_W-1:0] data;
  } resolved_t;

  resolved_t resolved_q[$];
  logic [prc_pkg::RST_BITS-1:0] restitution;

  function automatic longint comp(logic [V-1:0] p, int i);
    logic [C-1:0] r;
    r = C'(p >> (C*(2-i)));
    return longint'($signed(r));
  endfunction

  function automatic longint sat(longint v);
    longint hi;
    hi = (longint'(1) << (C-1)) - 1;
    if (v > hi) return hi;
    if (v < -hi-1) return -hi-1;
    return v;
  endfunction

  function automatic logic [V-1:0] nudge(logic [V-1:0] p, logic [V-1:0] n, longint q, bit sub);
    logic [V-1:0] r;
    longint d, c;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      d = (comp(n, i) * q) >>> FRACTION_BITS;
      c = sat(sub ? comp(p, i) - d : comp(p, i) + d);
      r = r | (V'(c & ((longint'(1) << C) - 1)) << (C*(2-i)));
    end
    return r;
  endfunction

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic resolved_t resolve(logic [IN_W-1:0] d, bit two);
    logic [V-1:0] va, vb, pa, pb, n, nva, nvb, npa, npb;
    longint depth, ima, imb, w, sep, dsp;
    logic [C-1:0] dep;
    resolved_t r;
    va = d[0 +: V]; vb = d[V +: V]; pa = d[2*V +: V]; pb = d[3*V +: V];
    n = d[4*V +: V];
    dep = d[5*V +: C];
    depth = longint'($signed(dep));
    ima = longint'(d[5*V+C +: prc_pkg::IM_BITS]);
    imb = two ? longint'(d[5*V+C+prc_pkg::IM_BITS +: prc_pkg::IM_BITS]) : 0;
    w = ima + imb;
    sep = 0;
    for (int i = 0; i < 3; i++)
      sep += (two ? comp(va, i) - comp(vb, i) : comp(va, i)) * comp(n, i);
    sep = sep >>> FRACTION_BITS;
    nva = va; nvb = vb; npa = pa; npb = pb;
    r.flags = 2'b00;
    if (sep <= 0 && w > 0) begin
      dsp = ((prc_pkg::RST_ONE + longint'(restitution)) * (-sep)) >>> prc_pkg::RST_SHIFT;
      nva = nudge(va, n, fdiv(dsp * ima, w), 1'b0);
      if (two) nvb = nudge(vb, n, fdiv(dsp * imb, w), 1'b1);
      r.flags[0] = 1'b1;
    end
    if (depth > 0 && w > 0) begin
      npa = nudge(pa, n, fdiv(depth * ima, w), 1'b0);
      if (two) npb = nudge(pb, n, fdiv(depth * imb, w), 1'b1);
      r.flags[1] = 1'b1;
    end
    r.data = '0;
    r.data[0 +: V] = nva; r.data[V +: V] = nvb;
    r.data[2*V +: V] = npa; r.data[3*V +: V] = npb;
    r.data[4*V +: C] = C'(sat(sep));
    return r;
  endfunction

  always_comb pending = resolved_q.size();

  always @(posedge clk) begin
    resolved_t e;
    if (rst) begin
      restitution <= '0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) restitution <= cfg_data;
      if (s_tvalid && s_tready) resolved_q.push_back(resolve(s_tdata, s_tuser[0]));
      if (m_tvalid && m_tready) begin
        if (resolved_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", m_tdata);
          errors <= errors + 1;
        end else begin
          e = resolved_q.pop_front();
          if (e.data !== m_tdata || e.flags !== m_tuser) begin
            if (errors < 10)
              $display("mismatch: exp %h/%b got %h/%b", e.data, e.flags, m_tdata, m_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/particle_contact_resolver_tb.sv
`timescale 1ns / 100ps
// Testbench top for particle_contact_resolver: drives contacts and restitution
// settings, stalls both sides; checking in particle_contact_checker.
module particle_contact_resolver_tb;
  localparam int C = 21;
  localparam int V = 3*C;
  localparam int IN_W  = ((16*C+2*prc_pkg::IM_BITS+7)/8)*8;
  localparam int OUT_W = ((13*C+7)/8)*8;
  localparam int LATENCY = 2*C - 10 + 33;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [prc_pkg::RST_BITS-1:0] cfg_data;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0] s_tdata;
  logic [0:0] s_tuser;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  int errors, pending;
  int cycles;
  bit stall_rx;

  particle_contact_resolver dut (.*);
  particle_contact_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int gap();
    return ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8) ?
           $urandom_range(1, 3) : $urandom_range(10, 40));
  endfunction

  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_rx) m_tready <= ($urandom_range(0, 3) != 0);
      else m_tready <= 1'b1;
    end
  end

  function automatic logic [V-1:0] vec(int mode);
    logic [V-1:0] r;
    logic [C-1:0] c;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: c = C'($urandom);
        1: c = C'($signed($urandom_range(0, 4000)) - 2000);
        default: c = $urandom_range(0, 1) ? {1'b0, {(C-1){1'b1}}} : {1'b1, {(C-1){1'b0}}};
      endcase
      r = (r << C) | V'(c);
    end
    return r;
  endfunction

  task automatic send(logic [IN_W-1:0] d, bit two);
    int g;
    g = gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tdata <= d;
    s_tuser <= two;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic contact(int mode, int dmode, int mmode, bit two);
    logic [IN_W-1:0] d;
    logic [C-1:0] dep;
    d = '0;
    for (int k = 0; k < 5; k++) d[k*V +: V] = vec(k == 4 && mode == 1 ? 1 : mode);
    case (dmode)
      0: dep = C'($urandom);
      1: dep = C'($urandom_range(0, 3000));
      default: dep = $urandom_range(0, 1) ? {1'b0, {(C-1){1'b1}}} : {1'b1, {(C-1){1'b0}}};
    endcase
    d[5*V +: C] = dep;
    for (int k = 0; k < 2; k++)
      d[5*V+C+k*prc_pkg::IM_BITS +: prc_pkg::IM_BITS] =
        mmode == 0 ? prc_pkg::IM_BITS'($urandom) :
        mmode == 1 ? prc_pkg::IM_BITS'($urandom_range(0, 8192)) :
        mmode == 2 ? '1 : '0;
    if ($urandom_range(0, 7) == 0) d[IN_W-1 -: 8] = 8'($urandom);
    send(d, two);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_restitution(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] rsets[5];
    rsets = '{16'd0, 16'd32768, 16'hFFFF, 16'd16384, 16'd0};
    rst = 1; cfg_valid = 0; cfg_data = '0; s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    stall_rx = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 24; k++)
      contact(k % 3, k % 3, k % 4, k[0]);
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      set_restitution(ph == 4 ? 16'($urandom) : rsets[ph]);
      stall_rx = (ph % 2 == 1);
      for (int k = 0; k < 150; k++) begin
        if (k == 75) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        contact($urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 2),
                $urandom_range(0, 2),
                $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3),
                $urandom_range(0, 1));
      end
    end
    s_tvalid <= 1'b0;
    stall_rx = 0;
    while (pending != 0 && cycles < 390000) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/prc_pkg.sv
hw/rtl/particle_contact_resolver.sv
tb/particle_contact_checker.sv
tb/particle_contact_resolver_tb.sv
